### rtl/sdlm_pkg.sv
// Shared types, constants and arithmetic helpers for the stereo delay line mixer.
// Depends on nothing; the core uses it by scoped names.
`default_nettype none

package sdlm_pkg;

  // Storage geometry
  localparam int BUFFER_DEPTH = 32768;
  localparam int CHANNELS     = 2;
  localparam int MAX_TAPS     = 4;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);

  // Field and arithmetic widths
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 14;
  localparam int DELAY_W    = 23;
  localparam int FRAC_W     = 8;
  localparam int TAP_DLY_W  = 16;
  localparam int CMP_W      = 17;
  localparam int COEF_W     = GAIN_W + 1;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int INTERP_W   = SAMPLE_W + FRAC_W + 1;
  localparam int WPROD_W    = INTERP_W + COEF_W;
  localparam int FIN_W      = WPROD_W + 2;
  localparam int FIN_SHIFT  = GAIN_FRAC + FRAC_W;
  localparam int RAM_W      = CHANNELS * SAMPLE_W;
  localparam int TAP_COUNT_W = 3;
  localparam int TAP_REGS   = 4;
  localparam int TAP_IDX_W  = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [WPROD_W-1:0]  wprod_t;
  typedef logic signed [FIN_W-1:0]    fin_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [ADDR_W:0]            addr_ext_t;
  typedef logic [FILL_W-1:0]          fill_t;
  typedef logic [CMP_W-1:0]           cmp_t;
  typedef logic [TAP_IDX_W-1:0]       tap_idx_t;
  typedef logic [TAP_COUNT_W-1:0]     tap_count_t;

  localparam cmp_t       MAX_READ_INT  = cmp_t'(BUFFER_DEPTH - 2);
  localparam cmp_t       MAX_TAP_DLY   = cmp_t'(BUFFER_DEPTH - 1);
  localparam tap_count_t TAPS_MAX      = tap_count_t'(MAX_TAPS);
  localparam tap_idx_t   LAST_FRAC_READ = tap_idx_t'(1);
  localparam gain_t      FRAC_ONE      = gain_t'(2 ** FRAC_W);
  localparam addr_ext_t  DEPTH_EXT     = addr_ext_t'(BUFFER_DEPTH);
  localparam fill_t      FILL_FULL     = fill_t'(BUFFER_DEPTH);

  localparam gain_t      WRITE_GAIN_RST = gain_t'(16384);
  localparam gain_t      WET_GAIN_RST   = gain_t'(4915);
  localparam gain_t      MIX_GAIN_RST   = gain_t'(16384);

  localparam fin_t    SAT_HI     = fin_t'(2 ** (SAMPLE_W - 1) - 1);
  localparam fin_t    SAT_LO     = fin_t'(-(2 ** (SAMPLE_W - 1)));
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};
  localparam acc_t    HALF_Q14   = acc_t'(2 ** (GAIN_FRAC - 1));
  localparam fin_t    HALF_FIN   = fin_t'(2 ** (FIN_SHIFT - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WRITE_GAIN = 4'd0,
    REG_WET_GAIN   = 4'd1,
    REG_MIX_GAIN   = 4'd2,
    REG_TAP_COUNT  = 4'd3,
    REG_TAP_ZERO   = 4'd4,
    REG_TAP_ONE    = 4'd5,
    REG_TAP_TWO    = 4'd6,
    REG_TAP_THREE  = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic [DELAY_W-1:0]         read_delay;
    logic                       frame_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       out_last;
  } out_item_t;

  // Clamp to the 16-bit sample range
  function automatic sample_t sat_sample(input fin_t v);
    sample_t r;
    if (v > SAT_HI) begin
      r = SAMPLE_MAX;
    end else if (v < SAT_LO) begin
      r = SAMPLE_MIN;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // Round half up at Q14, then saturate
  function automatic sample_t round_sat14(input acc_t v);
    acc_t t;
    t = v + HALF_Q14;
    return sat_sample(fin_t'(t >>> GAIN_FRAC));
  endfunction

  // Round half up at Q22, then saturate
  function automatic sample_t round_sat22(input fin_t v);
    fin_t t;
    t = v + HALF_FIN;
    return sat_sample(t >>> FIN_SHIFT);
  endfunction

endpackage

`default_nettype wire

### rtl/sdlm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
`default_nettype none

module sdlm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/stereo_delay_line_mixer_core.sv
// Stereo delay line mixer: ring store in one RAM, fractional or multi-tap read, dry/wet mix.
// Depends on sdlm_pkg and sdlm_ram.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    in_data   (sdlm_pkg::in_item_t)
//   output    out_valid / out_ready  out_data  (sdlm_pkg::out_item_t)
//   config    cfg_write              cfg_addr, cfg_data
//
// Each item makes two history reads in fractional mode and one to four with taps.
// The single read port of the history RAM issues one read per cycle.
// The next item is taken in the final cycle when the output register is free.
// Reset clears the write position and a fill count; entries not yet written read as
// zero through the fill count, so no clearing pass is needed.
// A stalled output holds its register and the block waits in its final state.
`default_nettype none

module stereo_delay_line_mixer_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sdlm_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sdlm_pkg::out_item_t                 out_data,
  input  logic                                cfg_write,
  input  logic [sdlm_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [sdlm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_WRITE  = 6'b000010,
    S_READ   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_SCALE  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  // Configuration
  sdlm_pkg::gain_t      write_gain, wet_gain, mix_gain;
  sdlm_pkg::tap_count_t tap_count;
  logic [sdlm_pkg::CFG_DATA_W-1:0] tap_reg [sdlm_pkg::TAP_REGS];

  // Item held for the duration of its work
  sdlm_pkg::sample_t dry [sdlm_pkg::CHANNELS];
  sdlm_pkg::addr_t   read_int;
  logic [sdlm_pkg::FRAC_W-1:0] read_frac;
  logic              frame_last;

  // Ring state
  sdlm_pkg::addr_t   wp;
  sdlm_pkg::fill_t   fill;

  // Read sequencer and pipeline
  sdlm_pkg::tap_idx_t k, last_k, last_k_next;
  sdlm_pkg::tap_count_t n_taps;
  logic              rd_v, rd_hit, rd_last;
  sdlm_pkg::gain_t   rd_coef;
  logic              pr_v, pr_last;

  sdlm_pkg::prod_t   prod   [sdlm_pkg::CHANNELS];
  sdlm_pkg::acc_t    acc    [sdlm_pkg::CHANNELS];
  sdlm_pkg::prod_t   drymix [sdlm_pkg::CHANNELS];
  sdlm_pkg::wprod_t  wprod  [sdlm_pkg::CHANNELS];
  sdlm_pkg::sample_t tap_out[sdlm_pkg::CHANNELS];

  // Combinational datapath
  sdlm_pkg::prod_t   store_prod [sdlm_pkg::CHANNELS];
  sdlm_pkg::sample_t store_val  [sdlm_pkg::CHANNELS];
  sdlm_pkg::prod_t   mix_prod   [sdlm_pkg::CHANNELS];
  sdlm_pkg::sample_t hist       [sdlm_pkg::CHANNELS];
  sdlm_pkg::acc_t    tap_sum    [sdlm_pkg::CHANNELS];
  sdlm_pkg::sample_t tap_val    [sdlm_pkg::CHANNELS];
  sdlm_pkg::fin_t    fin_sum    [sdlm_pkg::CHANNELS];
  sdlm_pkg::sample_t result     [sdlm_pkg::CHANNELS];

  logic              frac_mode;
  logic [sdlm_pkg::TAP_DLY_W-1:0] tap_dly;
  sdlm_pkg::addr_t   issue_dly;
  sdlm_pkg::gain_t   issue_coef;
  sdlm_pkg::addr_t   issue_addr;
  logic              issue_hit;
  logic [sdlm_pkg::DELAY_W-sdlm_pkg::FRAC_W-1:0] in_int;

  logic              in_xfer, out_free, load_out;

  // History RAM ports
  logic              ram_we, ram_re;
  logic [sdlm_pkg::RAM_W-1:0] ram_wdata, ram_rdata;

  assign frac_mode = (tap_count == '0);
  assign out_free  = !out_valid || out_ready;
  assign load_out  = (state == S_FINISH) && out_free;
  assign in_ready  = (state == S_IDLE) || load_out;
  assign in_xfer   = in_valid && in_ready;
  assign in_int    = in_data.read_delay[sdlm_pkg::DELAY_W-1:sdlm_pkg::FRAC_W];

  assign n_taps = (tap_count > sdlm_pkg::TAPS_MAX) ? sdlm_pkg::TAPS_MAX : tap_count;
  assign last_k_next = frac_mode ? sdlm_pkg::LAST_FRAC_READ
                                 : sdlm_pkg::tap_idx_t'(n_taps - 1'b1);

  // Read address and coefficient for read k
  always_comb begin
    tap_dly    = tap_reg[k][sdlm_pkg::TAP_DLY_W-1:0];
    issue_dly  = read_int;
    issue_coef = sdlm_pkg::FRAC_ONE - sdlm_pkg::gain_t'(read_frac);
    if (frac_mode) begin
      if (k != '0) begin
        issue_dly  = sdlm_pkg::addr_t'(read_int + 1'b1);
        issue_coef = sdlm_pkg::gain_t'(read_frac);
      end
    end else begin
      issue_dly  = ({1'b0, tap_dly} > sdlm_pkg::MAX_TAP_DLY)
                   ? sdlm_pkg::addr_t'(sdlm_pkg::MAX_TAP_DLY)
                   : sdlm_pkg::addr_t'(tap_dly);
      issue_coef = tap_reg[k][sdlm_pkg::CFG_DATA_W-1:sdlm_pkg::TAP_DLY_W];
    end
    if (wp >= issue_dly) begin
      issue_addr = sdlm_pkg::addr_t'({1'b0, wp} - {1'b0, issue_dly});
    end else begin
      issue_addr = sdlm_pkg::addr_t'({1'b0, wp} + sdlm_pkg::DEPTH_EXT - {1'b0, issue_dly});
    end
    // entries beyond the fill count were never written and read as zero
    issue_hit = sdlm_pkg::fill_t'(issue_dly) < fill;
  end

  // Per-lane arithmetic
  always_comb begin
    ram_wdata = '0;
    for (int c = 0; c < sdlm_pkg::CHANNELS; c++) begin
      store_prod[c] = dry[c] * $signed({1'b0, write_gain});
      store_val[c]  = sdlm_pkg::round_sat14(sdlm_pkg::acc_t'(store_prod[c]));
      mix_prod[c]   = dry[c] * $signed({1'b0, mix_gain});
      hist[c]       = rd_hit ? $signed(ram_rdata[c*sdlm_pkg::SAMPLE_W +: sdlm_pkg::SAMPLE_W])
                             : '0;
      tap_sum[c]    = acc[c] + sdlm_pkg::acc_t'(prod[c]);
      tap_val[c]    = sdlm_pkg::round_sat14(tap_sum[c]);
      fin_sum[c]    = (sdlm_pkg::fin_t'(drymix[c]) <<< sdlm_pkg::FRAC_W)
                      + sdlm_pkg::fin_t'(wprod[c]);
      result[c]     = frac_mode ? sdlm_pkg::round_sat22(fin_sum[c]) : tap_out[c];
      ram_wdata[c*sdlm_pkg::SAMPLE_W +: sdlm_pkg::SAMPLE_W] = store_val[c];
    end
  end

  assign ram_we = (state == S_WRITE);
  assign ram_re = (state == S_READ);

  sdlm_ram #(
    .WIDTH(sdlm_pkg::RAM_W),
    .DEPTH(sdlm_pkg::BUFFER_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (issue_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_WRITE;
      S_WRITE:  state_next = S_READ;
      S_READ:   if (k == last_k) state_next = S_DRAIN;
      S_DRAIN:  if (pr_v && pr_last) state_next = S_SCALE;
      S_SCALE:  state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_next = in_valid ? S_WRITE : S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wp         <= '0;
      fill       <= '0;
      k          <= '0;
      last_k     <= '0;
      rd_v       <= 1'b0;
      pr_v       <= 1'b0;
      out_valid  <= 1'b0;
      write_gain <= sdlm_pkg::WRITE_GAIN_RST;
      wet_gain   <= sdlm_pkg::WET_GAIN_RST;
      mix_gain   <= sdlm_pkg::MIX_GAIN_RST;
      tap_count  <= '0;
      for (int t = 0; t < sdlm_pkg::TAP_REGS; t++) begin
        tap_reg[t] <= '0;
      end
    end else begin
      state <= state_next;
      rd_v  <= (state == S_READ);
      pr_v  <= rd_v;
      if (state == S_WRITE) begin
        k      <= '0;
        last_k <= last_k_next;
        if (fill != sdlm_pkg::FILL_FULL) begin
          fill <= sdlm_pkg::fill_t'(fill + 1'b1);
        end
      end else if (state == S_READ) begin
        k <= sdlm_pkg::tap_idx_t'(k + 1'b1);
      end
      if (state == S_SCALE) begin
        // advance the ring once every read of the item is done
        wp <= (wp == sdlm_pkg::addr_t'(sdlm_pkg::BUFFER_DEPTH - 1))
              ? '0 : sdlm_pkg::addr_t'(wp + 1'b1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (sdlm_pkg::cfg_reg_t'(cfg_addr))
          sdlm_pkg::REG_WRITE_GAIN: write_gain <= cfg_data[sdlm_pkg::GAIN_W-1:0];
          sdlm_pkg::REG_WET_GAIN:   wet_gain   <= cfg_data[sdlm_pkg::GAIN_W-1:0];
          sdlm_pkg::REG_MIX_GAIN:   mix_gain   <= cfg_data[sdlm_pkg::GAIN_W-1:0];
          sdlm_pkg::REG_TAP_COUNT:  tap_count  <= cfg_data[sdlm_pkg::TAP_COUNT_W-1:0];
          sdlm_pkg::REG_TAP_ZERO, sdlm_pkg::REG_TAP_ONE,
          sdlm_pkg::REG_TAP_TWO, sdlm_pkg::REG_TAP_THREE:
            tap_reg[cfg_addr[sdlm_pkg::TAP_IDX_W-1:0]] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rd_last <= (k == last_k);
    rd_hit  <= issue_hit;
    rd_coef <= issue_coef;
    pr_last <= rd_last;
    if (in_xfer) begin
      for (int c = 0; c < sdlm_pkg::CHANNELS; c++) begin
        dry[c] <= (c == 0) ? in_data.left_sample : in_data.right_sample;
      end
      frame_last <= in_data.frame_last;
      if (sdlm_pkg::cmp_t'(in_int) > sdlm_pkg::MAX_READ_INT) begin
        read_int  <= sdlm_pkg::addr_t'(sdlm_pkg::MAX_READ_INT);
        read_frac <= '0;
      end else begin
        read_int  <= sdlm_pkg::addr_t'(in_int);
        read_frac <= in_data.read_delay[sdlm_pkg::FRAC_W-1:0];
      end
    end
    for (int c = 0; c < sdlm_pkg::CHANNELS; c++) begin
      if (state == S_WRITE) begin
        drymix[c] <= mix_prod[c];
        acc[c]    <= frac_mode ? '0 : sdlm_pkg::acc_t'(mix_prod[c]);
      end else if (pr_v) begin
        if (frac_mode) begin
          acc[c] <= tap_sum[c];
        end else begin
          // saturate after every tap, carry on in Q14
          acc[c]     <= sdlm_pkg::acc_t'(tap_val[c]) <<< sdlm_pkg::GAIN_FRAC;
          tap_out[c] <= tap_val[c];
        end
      end
      if (rd_v) begin
        prod[c] <= hist[c] * $signed({1'b0, rd_coef});
      end
      if (state == S_SCALE) begin
        wprod[c] <= $signed(acc[c][sdlm_pkg::INTERP_W-1:0]) * $signed({1'b0, wet_gain});
      end
    end
    if (load_out) begin
      out_data.left_out  <= result[0];
      out_data.right_out <= (sdlm_pkg::CHANNELS >= 2) ? result[sdlm_pkg::CHANNELS-1] : '0;
      out_data.out_last  <= frame_last;
    end
  end

  // The store and the reads never share a cycle, so no forwarding is needed
  a_ram_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("history RAM read and written in the same cycle");

  a_store_follows: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> ram_we)
    else $error("accepted frame not stored in the next cycle");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (fill != '0) && (fill <= sdlm_pkg::FILL_FULL))
    else $error("fill count out of range after a store");

  a_accum_window: assert property (@(posedge clk) disable iff (rst)
    pr_v |-> (state == S_READ || state == S_DRAIN))
    else $error("accumulation outside the read window");

  a_load_order: assert property (@(posedge clk) disable iff (rst)
    load_out |-> ($past(state) == S_SCALE || $past(state) == S_FINISH))
    else $error("result loaded before scaling");

endmodule

`default_nettype wire
